// ----- rtl/idt_pkg.sv -----
// Package with shared types, constants and lookup functions for the dither threshold block.
`default_nettype none
package idt_pkg;

  localparam int unsigned EDGE_W   = 5;
  localparam int unsigned LEVEL_W  = 5;
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned ENTRY_W  = 8;
  localparam int unsigned RANK_W   = 40;
  localparam int unsigned THR_W    = 16;
  localparam int unsigned CELLS_W  = 33;
  localparam int unsigned SQ_W     = 9;
  localparam int unsigned RECIP_W  = 24;
  localparam int unsigned QDEPTH   = 2;

  localparam logic [0:0] REG_BASE_EDGE = 1'b0;
  localparam logic [0:0] REG_LEVELS    = 1'b1;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_COMPUTE = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_COMPUTE,
    OP_CFG_ERR
  } op_kind_t;

  typedef struct packed {
    op_kind_t             kind;
    logic [ENTRY_W-1:0]   entry_index;
    logic [ENTRY_W-1:0]   entry_value;
    logic [COORD_W-1:0]   x_pos;
    logic [COORD_W-1:0]   y_pos;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_REM,
    ST_RD,
    ST_ACC,
    ST_CHK,
    ST_DIVQ,
    ST_OUT
  } back_state_t;

  // Reciprocal ceil(2^24 / edge), exact for 16-bit dividends.
  function automatic logic [RECIP_W-1:0] recip(input logic [EDGE_W-1:0] edge_len);
    logic [RECIP_W-1:0] r;
    unique case (edge_len)
      5'd2:    r = 24'd8388608;
      5'd3:    r = 24'd5592406;
      5'd4:    r = 24'd4194304;
      5'd5:    r = 24'd3355444;
      5'd6:    r = 24'd2796203;
      5'd7:    r = 24'd2396746;
      5'd8:    r = 24'd2097152;
      5'd9:    r = 24'd1864136;
      5'd10:   r = 24'd1677722;
      5'd11:   r = 24'd1525202;
      5'd12:   r = 24'd1398102;
      5'd13:   r = 24'd1290556;
      5'd14:   r = 24'd1198373;
      5'd15:   r = 24'd1118482;
      5'd16:   r = 24'd1048576;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Largest level count whose full edge stays within 65536; zero for an unusable edge.
  function automatic logic [LEVEL_W-1:0] max_levels(input logic [EDGE_W-1:0] edge_len);
    logic [LEVEL_W-1:0] m;
    unique case (edge_len)
      5'd2:    m = 5'd16;
      5'd3:    m = 5'd10;
      5'd4:    m = 5'd8;
      5'd5:    m = 5'd6;
      5'd6:    m = 5'd6;
      5'd7:    m = 5'd5;
      5'd8:    m = 5'd5;
      5'd9:    m = 5'd5;
      5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16: m = 5'd4;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/iterated_dither_threshold.sv -----
// Top level of the recursive ordered-dither threshold generator.
// A load item writes one base map entry. A compute item's result is formed by the per-level
// sequence (reciprocal digit split, remainder, map read, multiply-accumulate) and the 16-step
// restoring divider that scales the rank; a saturated threshold skips the divider, and a
// configuration error item goes straight to the output stage.
// A two-entry queue lets input items be taken while the back end works, and the output
// register holds a result until it is taken. Configuration is at byte addresses 0 (base_edge)
// and 4 (levels).
`default_nettype none
module iterated_dither_threshold (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_mode,
  input  wire logic [idt_pkg::ENTRY_W-1:0]  in_entry_index,
  input  wire logic [idt_pkg::ENTRY_W-1:0]  in_entry_value,
  input  wire logic [idt_pkg::COORD_W-1:0]  in_x_pos,
  input  wire logic [idt_pkg::COORD_W-1:0]  in_y_pos,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [idt_pkg::RANK_W-1:0]        out_rank,
  output logic [idt_pkg::THR_W-1:0]         out_threshold,
  output logic                              out_config_error
);

  logic [idt_pkg::EDGE_W-1:0]  edge_r;
  logic [idt_pkg::LEVEL_W-1:0] levels_r;
  logic                        cfg_wr;
  logic                        push;
  logic                        pop;
  idt_pkg::q_entry_t           push_entry;
  idt_pkg::q_entry_t           head;
  idt_pkg::q_status_t          q_status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    if (paddr[2] == idt_pkg::REG_LEVELS) begin
      prdata = {27'b0, levels_r};
    end else begin
      prdata = {27'b0, edge_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_r   <= 5'd2;
      levels_r <= 5'd1;
    end else if (cfg_wr) begin
      if (paddr[2] == idt_pkg::REG_BASE_EDGE) begin
        edge_r <= pwdata[idt_pkg::EDGE_W-1:0];
      end else begin
        levels_r <= pwdata[idt_pkg::LEVEL_W-1:0];
      end
    end
  end

  idt_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_x_pos       (in_x_pos),
    .in_y_pos       (in_y_pos),
    .base_edge      (edge_r),
    .levels         (levels_r),
    .q_status       (q_status),
    .push           (push),
    .push_entry     (push_entry)
  );

  idt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  idt_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .base_edge        (edge_r),
    .levels           (levels_r),
    .head             (head),
    .q_status         (q_status),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rank         (out_rank),
    .out_threshold    (out_threshold),
    .out_config_error (out_config_error)
  );

endmodule
`default_nettype wire

// ----- rtl/idt_front.sv -----
// Front end: accepts input items and classifies them into queue entries.
`default_nettype none
module idt_front (
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_mode,
  input  wire logic [idt_pkg::ENTRY_W-1:0]  in_entry_index,
  input  wire logic [idt_pkg::ENTRY_W-1:0]  in_entry_value,
  input  wire logic [idt_pkg::COORD_W-1:0]  in_x_pos,
  input  wire logic [idt_pkg::COORD_W-1:0]  in_y_pos,
  input  wire logic [idt_pkg::EDGE_W-1:0]   base_edge,
  input  wire logic [idt_pkg::LEVEL_W-1:0]  levels,
  input  wire idt_pkg::q_status_t           q_status,
  output logic                              push,
  output idt_pkg::q_entry_t                 push_entry
);

  logic cfg_ok;

  assign cfg_ok = (levels != '0) && (levels <= idt_pkg::max_levels(base_edge));
  assign in_stall = q_status.full;
  assign push = in_valid && !q_status.full;

  always_comb begin
    push_entry.entry_index = in_entry_index;
    push_entry.entry_value = in_entry_value;
    push_entry.x_pos       = in_x_pos;
    push_entry.y_pos       = in_y_pos;
    if (in_mode == idt_pkg::MODE_LOAD) begin
      push_entry.kind = idt_pkg::OP_LOAD;
    end else if (cfg_ok) begin
      push_entry.kind = idt_pkg::OP_COMPUTE;
    end else begin
      push_entry.kind = idt_pkg::OP_CFG_ERR;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/idt_queue.sv -----
// Two-entry queue between the front end and the back end.
`default_nettype none
module idt_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire idt_pkg::q_entry_t  push_entry,
  input  wire logic               pop,
  output idt_pkg::q_entry_t       head,
  output idt_pkg::q_status_t      status
);

  idt_pkg::q_entry_t store_r [idt_pkg::QDEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign head         = store_r[rd_ptr_r];
  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/idt_back.sv -----
// Back end: base map memory, digit sequencer, rank accumulation, scaling divider and output register.
`default_nettype none
module idt_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [idt_pkg::EDGE_W-1:0]   base_edge,
  input  wire logic [idt_pkg::LEVEL_W-1:0]  levels,
  input  wire idt_pkg::q_entry_t            head,
  input  wire idt_pkg::q_status_t           q_status,
  output logic                              pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [idt_pkg::RANK_W-1:0]        out_rank,
  output logic [idt_pkg::THR_W-1:0]         out_threshold,
  output logic                              out_config_error
);

  idt_pkg::back_state_t state_r, state_nxt;

  logic [idt_pkg::ENTRY_W-1:0]  mem [2**idt_pkg::ENTRY_W];
  logic [idt_pkg::ENTRY_W-1:0]  rdata_r;
  logic [idt_pkg::COORD_W-1:0]  x_r, y_r, qx_r, qy_r;
  logic [3:0]                   xd_r, yd_r;
  logic [idt_pkg::RANK_W-1:0]   rank_r;
  logic [idt_pkg::CELLS_W-1:0]  cells_r, rem_r;
  logic [idt_pkg::THR_W-1:0]    quo_r;
  logic                         err_r;
  logic [idt_pkg::LEVEL_W-1:0]  lvl_r;
  logic [3:0]                   cnt_r;
  logic                         out_valid_r;
  logic [idt_pkg::RANK_W-1:0]   out_rank_r;
  logic [idt_pkg::THR_W-1:0]    out_thr_r;
  logic                         out_err_r;

  logic [idt_pkg::SQ_W-1:0]     sq;
  logic [39:0]                  prod_x, prod_y;
  logic [idt_pkg::RECIP_W-1:0]  m;
  logic [idt_pkg::COORD_W-1:0]  rx, ry;
  logic [8:0]                   idx_wide;
  logic [idt_pkg::ENTRY_W-1:0]  rd_addr;
  logic [idt_pkg::RANK_W-1:0]   rank_acc;
  logic [idt_pkg::CELLS_W-1:0]  cells_acc;
  logic [idt_pkg::CELLS_W:0]    shifted;
  logic                         ge;
  logic                         out_free;
  logic                         out_load;

  assign sq        = idt_pkg::SQ_W'({4'b0, base_edge} * {4'b0, base_edge});
  assign m         = idt_pkg::recip(base_edge);
  assign prod_x    = {24'b0, x_r} * {16'b0, m};
  assign prod_y    = {24'b0, y_r} * {16'b0, m};
  assign rx        = x_r - 16'({11'b0, base_edge} * qx_r);
  assign ry        = y_r - 16'({11'b0, base_edge} * qy_r);
  assign idx_wide  = {5'b0, yd_r} + 9'({4'b0, xd_r} * {4'b0, base_edge});
  assign rd_addr   = idx_wide[7:0];
  assign rank_acc  = 40'(rank_r * {31'b0, sq}) + {32'b0, rdata_r};
  assign cells_acc = 33'(cells_r * {24'b0, sq});
  assign shifted   = {rem_r, 1'b0};
  assign ge        = shifted >= {1'b0, cells_r};
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == idt_pkg::ST_OUT) && out_free;
  assign pop       = (state_r == idt_pkg::ST_IDLE) && !q_status.empty;

  assign out_valid        = out_valid_r;
  assign out_rank         = out_rank_r;
  assign out_threshold    = out_thr_r;
  assign out_config_error = out_err_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      idt_pkg::ST_IDLE: begin
        if (pop) begin
          unique case (head.kind)
            idt_pkg::OP_COMPUTE: state_nxt = idt_pkg::ST_DIV;
            idt_pkg::OP_CFG_ERR: state_nxt = idt_pkg::ST_OUT;
            default:             state_nxt = idt_pkg::ST_IDLE;
          endcase
        end
      end
      idt_pkg::ST_DIV:  state_nxt = idt_pkg::ST_REM;
      idt_pkg::ST_REM:  state_nxt = idt_pkg::ST_RD;
      idt_pkg::ST_RD:   state_nxt = idt_pkg::ST_ACC;
      idt_pkg::ST_ACC:  state_nxt = (lvl_r == 5'd1) ? idt_pkg::ST_CHK : idt_pkg::ST_DIV;
      idt_pkg::ST_CHK: begin
        state_nxt = (rank_r >= {7'b0, cells_r}) ? idt_pkg::ST_OUT : idt_pkg::ST_DIVQ;
      end
      idt_pkg::ST_DIVQ: state_nxt = (cnt_r == 4'd0) ? idt_pkg::ST_OUT : idt_pkg::ST_DIVQ;
      idt_pkg::ST_OUT:  state_nxt = out_free ? idt_pkg::ST_IDLE : idt_pkg::ST_OUT;
      default:          state_nxt = idt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= idt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.kind == idt_pkg::OP_LOAD) begin
      mem[head.entry_index] <= head.entry_value;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      idt_pkg::ST_IDLE: begin
        x_r     <= head.x_pos;
        y_r     <= head.y_pos;
        rank_r  <= '0;
        cells_r <= 33'd1;
        lvl_r   <= levels;
        quo_r   <= '0;
        err_r   <= (head.kind == idt_pkg::OP_CFG_ERR);
      end
      idt_pkg::ST_DIV: begin
        qx_r <= prod_x[39:24];
        qy_r <= prod_y[39:24];
      end
      idt_pkg::ST_REM: begin
        xd_r <= rx[3:0];
        yd_r <= ry[3:0];
        x_r  <= qx_r;
        y_r  <= qy_r;
      end
      idt_pkg::ST_RD: begin
      end
      idt_pkg::ST_ACC: begin
        rank_r  <= rank_acc;
        cells_r <= cells_acc;
        lvl_r   <= lvl_r - 5'd1;
      end
      idt_pkg::ST_CHK: begin
        rem_r <= rank_r[idt_pkg::CELLS_W-1:0];
        cnt_r <= 4'd15;
        if (rank_r >= {7'b0, cells_r}) begin
          quo_r <= '1;
        end
      end
      idt_pkg::ST_DIVQ: begin
        rem_r <= ge ? 33'(shifted - {1'b0, cells_r}) : shifted[idt_pkg::CELLS_W-1:0];
        quo_r <= {quo_r[idt_pkg::THR_W-2:0], ge};
        cnt_r <= cnt_r - 4'd1;
      end
      idt_pkg::ST_OUT: begin
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_rank_r <= rank_r;
      out_thr_r  <= quo_r;
      out_err_r  <= err_r;
    end
  end

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == idt_pkg::ST_RD) |-> ({1'b0, xd_r} < base_edge && {1'b0, yd_r} < base_edge))
    else $error("digit not below the radix");

  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == idt_pkg::ST_DIVQ) |-> (rem_r < cells_r))
    else $error("divider remainder not below cell count");

  a_out_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("output register not loaded");

endmodule
`default_nettype wire
